FILE: design/dlfr_pkg.sv
// dlfr_pkg: shared types and constants for the delay line frame receiver
// no dependencies; used by dlfr_core and delay_line_frame_receiver

package dlfr_pkg;

    localparam int FRAME_BYTES  = 7;
    localparam int HOLD_BYTES   = FRAME_BYTES - 1;
    localparam int FILL_W       = 3;

    localparam logic [7:0] START_BYTE   = 8'hFC;
    localparam logic [7:0] END_BYTE     = 8'hFE;
    localparam logic [7:0] CMD_POSITION = 8'hAA;

    localparam logic REG_DEVICE_ID = 1'b0;
    localparam logic REG_STABLE_TH = 1'b1;

    localparam logic [7:0] DEVICE_ID_RST = 8'd1;
    localparam logic [7:0] STABLE_TH_RST = 8'd3;
    localparam logic [7:0] STABLE_MAX    = 8'hFF;

    localparam int RESULT_W = 62;
    localparam int TDATA_W  = 64;

    // last field in the lowest bits
    typedef struct packed {
        logic        move_done;
        logic        moving;
        logic [23:0] position;
        logic        position_valid;
        logic [23:0] payload;
        logic [7:0]  command;
        logic        dropped_byte;
        logic        id_mismatch;
        logic        frame_taken;
    } result_t;

endpackage

FILE: design/dlfr_core.sv
// dlfr_core: byte window, frame delimiting, id match and motion tracking
// depends on dlfr_pkg

module dlfr_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic                   cfg_addr,
    input  logic [7:0]             cfg_wdata,
    input  logic                   byte_en,
    input  logic [7:0]             rx_byte,
    output dlfr_pkg::result_t      result
);

    logic [7:0]                    wnd_reg [dlfr_pkg::HOLD_BYTES];
    logic [dlfr_pkg::FILL_W-1:0]   fill_reg;
    logic [23:0]                   position_reg;
    logic [7:0]                    stable_reg;
    logic                          moving_reg;
    logic [7:0]                    device_id_reg;
    logic [7:0]                    stable_th_reg;

    logic        full;
    logic        framed;
    logic        id_ok;
    logic [7:0]  cmd;
    logic [23:0] data;
    logic        pos_upd;
    logic        same;
    logic [7:0]  stable_inc;
    logic        done;
    logic [7:0]  stable_next;
    logic        moving_next;

    always_comb begin
        full        = fill_reg == dlfr_pkg::FILL_W'(dlfr_pkg::HOLD_BYTES);
        framed      = full && (wnd_reg[0] == dlfr_pkg::START_BYTE)
                      && (rx_byte == dlfr_pkg::END_BYTE);
        id_ok       = wnd_reg[1] == device_id_reg;
        cmd         = wnd_reg[2];
        data        = {wnd_reg[3], wnd_reg[4], wnd_reg[5]};
        pos_upd     = framed && id_ok && (cmd == dlfr_pkg::CMD_POSITION);
        same        = data == position_reg;
        stable_inc  = (stable_reg == dlfr_pkg::STABLE_MAX) ? stable_reg : stable_reg + 8'd1;
        done        = pos_upd && same && moving_reg && (stable_inc >= stable_th_reg);
        stable_next = stable_reg;
        moving_next = moving_reg;
        if (pos_upd) begin
            if (same) begin
                stable_next = stable_inc;
                if (done) begin
                    moving_next = 1'b0;
                end
            end else begin
                stable_next = 8'd0;
                moving_next = 1'b1;
            end
        end

        result.frame_taken    = framed && id_ok;
        result.id_mismatch    = framed && !id_ok;
        result.dropped_byte   = full && !framed;
        result.command        = framed ? cmd : 8'd0;
        result.payload        = framed ? data : 24'd0;
        result.position_valid = pos_upd;
        result.position       = pos_upd ? data : position_reg;
        result.moving         = moving_next;
        result.move_done      = done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_id_reg <= dlfr_pkg::DEVICE_ID_RST;
            stable_th_reg <= dlfr_pkg::STABLE_TH_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                dlfr_pkg::REG_DEVICE_ID: device_id_reg <= cfg_wdata;
                dlfr_pkg::REG_STABLE_TH: stable_th_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            position_reg <= '0;
            stable_reg   <= '0;
            moving_reg   <= 1'b0;
        end else if (byte_en) begin
            position_reg <= result.position;
            stable_reg   <= stable_next;
            moving_reg   <= moving_next;
            if (!full) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (framed) begin
                fill_reg <= '0;
            end
        end
    end

    // window payload, no reset
    always_ff @(posedge aclk) begin
        if (byte_en) begin
            if (!full) begin
                wnd_reg[fill_reg] <= rx_byte;
            end else if (!framed) begin
                for (int i = 0; i < dlfr_pkg::HOLD_BYTES - 1; i++) begin
                    wnd_reg[i] <= wnd_reg[i+1];
                end
                wnd_reg[dlfr_pkg::HOLD_BYTES-1] <= rx_byte;
            end
        end
    end

endmodule

FILE: design/delay_line_frame_receiver.sv
// delay_line_frame_receiver: top level, stream ports and output skid buffer
// depends on dlfr_pkg and dlfr_core
// each result is registered in out_reg, or first in skid_reg when the output stalls
// throughput: one item per cycle while s_tready is high; one result per input item
// a two-entry output (register plus skid) keeps s_tready high while one result waits
// reset: synchronous active-low aresetn clears window fill, position, motion state
// and the registers to device id 1 and settle limit 3

module delay_line_frame_receiver (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic                         cfg_addr,
    input  logic [7:0]                   cfg_wdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // rx_byte
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // frame_taken, id_mismatch, dropped_byte, command[7:0], payload[23:0],
    // position_valid, position[23:0], moving, move_done, zero fill
    output logic [dlfr_pkg::TDATA_W-1:0] m_tdata
);

    logic               accept;
    dlfr_pkg::result_t  res;
    dlfr_pkg::result_t  out_reg;
    dlfr_pkg::result_t  skid_reg;
    logic               out_valid_reg;
    logic               skid_valid_reg;
    logic               drain;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign drain    = m_tready || !out_valid_reg;

    dlfr_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .byte_en   (accept),
        .rx_byte   (s_tdata),
        .result    (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (drain) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (drain) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (accept) begin
                out_reg <= res;
            end
        end else if (accept) begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(dlfr_pkg::TDATA_W - dlfr_pkg::RESULT_W)'(0), out_reg};

endmodule

FILE: design/dlfr_checker.sv
// dlfr_checker: port-level checks on the result stream of the receiver
// depends on nothing; bound to delay_line_frame_receiver below

module dlfr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // stalled item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $countones(m_tdata[2:0]) <= 1)
        else $error("more than one item kind flagged");

    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[61] |-> !m_tdata[60] && m_tdata[35])
        else $error("move_done without stop on position reply");

    a_posv: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[35] |-> m_tdata[0] && m_tdata[10:3] == 8'hAA)
        else $error("position update without taken position reply");

    a_noframe: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] && !m_tdata[1] |-> m_tdata[34:3] == 32'd0)
        else $error("command or payload set without a frame");

endmodule

bind delay_line_frame_receiver dlfr_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
